// ----- hw/rtl/chc_pkg.sv -----
// shared types and constants for the capacitive humidity converter
// no dependencies; imported by every module of the block
package chc_pkg;

  // input word: raw counts from the sensing and the reference capacitor
  typedef struct packed {
    logic [15:0] sensor_count;
    logic [15:0] reference_count;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [15:0] sensor_capacitance;
    logic [9:0]  relative_humidity;
    logic        reference_invalid;
  } out_word_t;

  // divider working word: remainder, numerator bits shifting out / quotient shifting in
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] work;
    logic [15:0] den;
    logic        ref_inv;
    logic        cap_zero;
    logic        cap_sat;
  } div_word_t;

  // configuration register indexes
  localparam logic [1:0] REG_OFFSET  = 2'd0;
  localparam logic [1:0] REG_SPAN    = 2'd1;
  localparam logic [1:0] REG_NOMINAL = 2'd2;

  localparam logic [15:0] OFFSET_RST  = 16'd1536;
  localparam logic [11:0] SPAN_RST    = 12'd1780;
  localparam logic [15:0] NOMINAL_RST = 16'd1850;

  localparam logic [15:0] CAP_MAX = 16'hFFFF;

  // divider layout: 16 quotient bits over 4 stages
  localparam int DIV_STAGES          = 4;
  localparam int DIV_STEPS_PER_STAGE = 4;

  // humidity: beyond +-200 counts of delta the result always clamps
  localparam logic [16:0] DELTA_LIM = 17'd200;
  // 100 * ceil(2^20 / 31): exact for |delta| * 100 up to 34952
  localparam logic [29:0] RECIP_K     = 30'd3382600;
  localparam logic [11:0] RH_NOMINAL  = 12'd550;
  localparam logic [11:0] RH_MAX      = 12'd1000;

endpackage

// ----- hw/rtl/capacitive_humidity_converter_unit.sv -----
// top level of the capacitive humidity converter: config registers and pipeline control
// depends on chc_pkg, chc_prep, chc_div_stage, chc_humid
//
// usage
// - input channel in_valid / in_stall / in_word: one word holds a sensor count and a
//   reference count; a word is taken at a clock edge with in_valid high and in_stall low
// - result channel out_valid / out_stall / out_word: capacitance in 0.1 pF (saturated
//   to 16 bits), humidity in 0.1 percent (0..1000) and the reference-invalid flag
// - config channel cfg_valid / cfg_ready / cfg_index / cfg_data: index 0 offset count,
//   1 capacitance span, 2 nominal capacitance; cfg_ready is always high, other indexes
//   are dropped; write only while no word is in flight
// - pipeline: 10 register stages (3 front stages, 4 divider stages of 4 quotient bits
//   each, 3 humidity stages with the result register last)
// - throughput: one word per cycle while out_stall is low, set by the fully pipelined divider
// - stall: every stage holds its word while the stage after it is full and stalled;
//   empty stages keep filling, so in_stall rises only once all 10 stages are full
// - reset: synchronous, active low; empties the pipeline and loads the default
//   offset 1536, span 1780 and nominal 1850
module capacitive_humidity_converter_unit import chc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NSTG = 3 + DIV_STAGES + 3;

  // configuration registers
  logic [15:0] offset_r;
  logic [11:0] span_r;
  logic [15:0] nominal_r;

  // per-stage valid and advance
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  div_word_t div_w [DIV_STAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r  <= OFFSET_RST;
      span_r    <= SPAN_RST;
      nominal_r <= NOMINAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET:  offset_r  <= cfg_data;
        REG_SPAN:    span_r    <= cfg_data[11:0];
        REG_NOMINAL: nominal_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage advances when it is empty or the next stage advances
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  chc_prep u_prep (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (en[2:0]),
    .in_vld           (in_valid),
    .in_word          (in_word),
    .offset_count     (offset_r),
    .capacitance_span (span_r),
    .vld              (vld[2:0]),
    .div_word         (div_w[0])
  );

  // divider stages, each resolving a nibble of the quotient
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    chc_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (en[3+g]),
      .in_vld  (vld[2+g]),
      .div_in  (div_w[g]),
      .vld     (vld[3+g]),
      .div_out (div_w[g+1])
    );
  end

  chc_humid u_humid (
    .clk                 (clk),
    .rst_n               (rst_n),
    .adv                 (en[NSTG-1:NSTG-3]),
    .in_vld              (vld[NSTG-4]),
    .div_word            (div_w[DIV_STAGES]),
    .nominal_capacitance (nominal_r),
    .vld                 (vld[NSTG-1:NSTG-3]),
    .out_word            (out_word)
  );

  assign out_valid = vld[NSTG-1];

endmodule

// ----- hw/rtl/chc_prep.sv -----
// front stages: count differences, span multiply, overflow check, divider setup
// depends on chc_pkg
module chc_prep import chc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  adv,
  input  logic        in_vld,
  input  in_word_t    in_word,
  input  logic [15:0] offset_count,
  input  logic [11:0] capacitance_span,
  output logic [2:0]  vld,
  output div_word_t   div_word
);

  logic [2:0]  vld_r;
  logic [16:0] sens_diff;
  logic [16:0] ref_diff;
  logic [15:0] diff_r;
  logic        neg_r;
  logic [15:0] den_r;
  logic        inv_r;
  logic [27:0] num2_r;
  logic [15:0] den2_r;
  logic        zero2_r;
  logic        inv2_r;
  logic        ovf;
  div_word_t   div_word_r;

  assign sens_diff = {1'b0, in_word.sensor_count} - {1'b0, offset_count};
  assign ref_diff  = {1'b0, in_word.reference_count} - {1'b0, offset_count};
  assign ovf       = {4'b0, num2_r[27:16]} >= den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_vld;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      diff_r <= sens_diff[15:0];
      neg_r  <= sens_diff[16];
      den_r  <= ref_diff[15:0];
      // reference at or below offset
      inv_r  <= ref_diff[16] || (ref_diff[15:0] == 16'd0);
    end
    if (adv[1]) begin
      num2_r  <= 28'(diff_r) * 28'(capacitance_span);
      den2_r  <= den_r;
      zero2_r <= neg_r;
      inv2_r  <= inv_r;
    end
    if (adv[2]) begin
      div_word_r.rem      <= ovf ? 16'd0 : {4'b0, num2_r[27:16]};
      div_word_r.work     <= num2_r[15:0];
      div_word_r.den      <= den2_r;
      div_word_r.ref_inv  <= inv2_r;
      div_word_r.cap_zero <= zero2_r;
      div_word_r.cap_sat  <= ovf;
    end
  end

  assign vld      = vld_r;
  assign div_word = div_word_r;

endmodule

// ----- hw/rtl/chc_div_stage.sv -----
// one registered stage of the restoring divider, DIV_STEPS_PER_STAGE (4) quotient bits per stage
// depends on chc_pkg
module chc_div_stage import chc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  logic      in_vld,
  input  div_word_t div_in,
  output logic      vld,
  output div_word_t div_out
);

  function automatic div_word_t div_step(input div_word_t d);
    div_word_t   r;
    logic [16:0] t;
    logic [16:0] diff;
    r    = d;
    t    = {d.rem, d.work[15]};
    diff = t - {1'b0, d.den};
    if (!diff[16]) begin
      r.rem  = diff[15:0];
      r.work = {d.work[14:0], 1'b1};
    end else begin
      r.rem  = t[15:0];
      r.work = {d.work[14:0], 1'b0};
    end
    return r;
  endfunction

  logic      vld_r;
  div_word_t div_r;
  div_word_t stp [DIV_STEPS_PER_STAGE+1];

  always_comb begin
    stp[0] = div_in;
    for (int i = 0; i < DIV_STEPS_PER_STAGE; i++) begin
      stp[i+1] = div_step(stp[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      div_r <= stp[DIV_STEPS_PER_STAGE];
    end
  end

  assign vld     = vld_r;
  assign div_out = div_r;

endmodule

// ----- hw/rtl/chc_humid.sv -----
// back stages: capacitance select, humidity scaling by 100/31, clamp, result register
// depends on chc_pkg
module chc_humid import chc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  adv,
  input  logic        in_vld,
  input  div_word_t   div_word,
  input  logic [15:0] nominal_capacitance,
  output logic [2:0]  vld,
  output out_word_t   out_word
);

  logic [2:0]        vld_r;
  logic [15:0]       cap;
  logic [16:0]       delta;
  logic [16:0]       mag;
  logic [16:0]       mag_lim;
  logic [15:0]       cap1_r;
  logic              sign1_r;
  logic [7:0]        abs1_r;
  logic              inv1_r;
  logic [29:0]       prod;
  logic [9:0]        q2_r;
  logic              sign2_r;
  logic [15:0]       cap2_r;
  logic              inv2_r;
  logic signed [11:0] rh;
  logic [9:0]        rh_clamp;
  out_word_t         out_r;

  always_comb begin
    // a sensor count below offset wins over the overflow check of its wrapped product
    if (div_word.cap_zero) begin
      cap = 16'd0;
    end else if (div_word.cap_sat) begin
      cap = CAP_MAX;
    end else begin
      cap = div_word.work;
    end
    delta   = {1'b0, cap} - {1'b0, nominal_capacitance};
    mag     = delta[16] ? (17'd0 - delta) : delta;
    mag_lim = (mag > DELTA_LIM) ? DELTA_LIM : mag;
  end

  assign prod = 30'(abs1_r) * RECIP_K;

  always_comb begin
    rh = sign2_r ? $signed(RH_NOMINAL - 12'(q2_r)) : $signed(RH_NOMINAL + 12'(q2_r));
    if (rh < 12'sd0) begin
      rh_clamp = 10'd0;
    end else if (rh > $signed(RH_MAX)) begin
      rh_clamp = RH_MAX[9:0];
    end else begin
      rh_clamp = rh[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_vld;
      if (adv[1]) vld_r[1] <= vld_r[0];
      if (adv[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cap1_r  <= cap;
      sign1_r <= delta[16];
      abs1_r  <= mag_lim[7:0];
      inv1_r  <= div_word.ref_inv;
    end
    if (adv[1]) begin
      q2_r    <= prod[29:20];
      sign2_r <= sign1_r;
      cap2_r  <= cap1_r;
      inv2_r  <= inv1_r;
    end
    if (adv[2]) begin
      out_r.sensor_capacitance <= inv2_r ? 16'd0 : cap2_r;
      out_r.relative_humidity  <= inv2_r ? 10'd0 : rh_clamp;
      out_r.reference_invalid  <= inv2_r;
    end
  end

  assign vld      = vld_r;
  assign out_word = out_r;

endmodule
